/* sv/pli_pkg.sv */
// ----------------------------------------------------------------------------
// pli_pkg
// Shared codes, widths and controller/datapath interface types for the
// piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

  // Data widths fixed by the request format
  localparam int POS_W    = 32;
  localparam int LVL_W    = 32;
  localparam int CFG_DW   = 16;
  localparam int DIV_STEPS = 32;

  // Function codes
  localparam logic [1:0] FN_BP    = 2'd0;
  localparam logic [1:0] FN_LV    = 2'd1;
  localparam logic [1:0] FN_QUERY = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_INTERP = 3'd0;
  localparam logic [2:0] ST_BELOW  = 3'd1;
  localparam logic [2:0] ST_CLAMP  = 3'd2;
  localparam logic [2:0] ST_BEYOND = 3'd3;
  localparam logic [2:0] ST_WRITE  = 3'd4;
  localparam logic [2:0] ST_NOSEG  = 3'd5;

  // Configuration register indexes
  localparam logic CFG_POINTS = 1'b0;
  localparam logic CFG_TOL    = 1'b1;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_WRITE,
    OP_SET,
    OP_WRAP,
    OP_RD_LO,
    OP_RD_HI,
    OP_CHECK,
    OP_STEP,
    OP_RD_Y1,
    OP_RD_Y2,
    OP_PREP,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_INTERP,
    OP_RD_CLAMP,
    OP_CLAMP
  } dp_op_t;

  // Controller to datapath
  typedef struct packed {
    dp_op_t     op;
    logic [2:0] st;    // status code for OP_SET
    logic       push;  // move result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       curve_big;
    logic       below;
    logic       beyond;
    logic       clamp;
    logic       hit;
    logic       last;
    logic       out_free;
  } sts_t;

endpackage

/* sv/piecewise_linear_interpolator_unit.sv */
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit
// Top level: breakpoint/level table with linear-search interpolation.
// ----------------------------------------------------------------------------
// One request is handled at a time. Breakpoint writes, level writes and
// unused function codes go straight to the result hand-off. A query at or
// below the first breakpoint, or beyond the last one by more than the
// tolerance, ends after the bounds check; one within the tolerance is
// clamped. An interpolating query searches linearly for its segment: the
// search reads one breakpoint per cycle from the single-port breakpoint
// memory, and the quotient comes from a one bit per cycle restoring
// divider. A curve index at or above NUM_CURVES is first wrapped down by
// NUM_CURVES, one wrap step at a time. The result sits in an output
// register, so a new request is taken as soon as the result is handed over
// there, even while it waits for out_ready. No clearing pass after reset:
// table entries read before they are written return unspecified data.
module piecewise_linear_interpolator_unit #(
  parameter int MAX_POINTS = 32,
  parameter int NUM_CURVES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write port
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [5:0]         in_curve,
  input  logic [4:0]         in_point,
  input  logic [31:0]        in_position,
  input  logic signed [31:0] in_level,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_value,
  output logic [2:0]         out_status
);

  pli_pkg::cmd_t cmd;
  pli_pkg::sts_t sts;

  // Sequencer
  pli_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables and arithmetic
  pli_dp #(
    .MAX_POINTS (MAX_POINTS),
    .NUM_CURVES (NUM_CURVES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_func     (in_func),
    .in_curve    (in_curve),
    .in_point    (in_point),
    .in_position (in_position),
    .in_level    (in_level),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_value   (out_value),
    .out_status  (out_status)
  );

endmodule

/* sv/pli_ctrl.sv */
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for one request at a time: table writes, curve wrap, bounds check,
// linear segment search, level reads, multiply, divide, clamp and result hand-off.
// ----------------------------------------------------------------------------
module pli_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pli_pkg::sts_t sts,
  output pli_pkg::cmd_t cmd
);

  localparam int CW = $clog2(pli_pkg::DIV_STEPS);

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_WRAP,
    S_RD_LO,
    S_RD_HI,
    S_CHK,
    S_SEARCH,
    S_LV1,
    S_LV2,
    S_PREP,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV_INIT,
    S_DIV,
    S_INTERP,
    S_CL_RD,
    S_CL_SET,
    S_FINISH
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.op    = pli_pkg::OP_NONE;
    cmd.st    = pli_pkg::ST_NOSEG;
    cmd.push  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = pli_pkg::OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.func == pli_pkg::FN_BP || sts.func == pli_pkg::FN_LV) begin
          cmd.op    = pli_pkg::OP_WRITE;
          state_nxt = S_FINISH;
        end else if (sts.func == pli_pkg::FN_QUERY) begin
          state_nxt = S_WRAP;
        end else begin
          cmd.op    = pli_pkg::OP_SET;
          cmd.st    = pli_pkg::ST_NOSEG;
          state_nxt = S_FINISH;
        end
      end
      S_WRAP: begin
        if (sts.curve_big) begin
          cmd.op = pli_pkg::OP_WRAP;
        end else begin
          state_nxt = S_RD_LO;
        end
      end
      S_RD_LO: begin
        cmd.op    = pli_pkg::OP_RD_LO;
        state_nxt = S_RD_HI;
      end
      S_RD_HI: begin
        cmd.op    = pli_pkg::OP_RD_HI;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.op = pli_pkg::OP_CHECK;
        if (sts.below || sts.beyond) begin
          state_nxt = S_FINISH;
        end else if (sts.clamp) begin
          state_nxt = S_CL_RD;
        end else begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.op = pli_pkg::OP_STEP;
        if (sts.hit) begin
          state_nxt = S_LV1;
        end else if (sts.last) begin
          state_nxt = S_FINISH;
        end
      end
      S_LV1: begin
        cmd.op    = pli_pkg::OP_RD_Y1;
        state_nxt = S_LV2;
      end
      S_LV2: begin
        cmd.op    = pli_pkg::OP_RD_Y2;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.op    = pli_pkg::OP_PREP;
        state_nxt = S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.op    = pli_pkg::OP_MUL_LO;
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.op    = pli_pkg::OP_MUL_HI;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.op    = pli_pkg::OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op = pli_pkg::OP_DIV_STEP;
        if (cnt_r == CW'(pli_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_INTERP;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end
      S_INTERP: begin
        cmd.op    = pli_pkg::OP_INTERP;
        state_nxt = S_FINISH;
      end
      S_CL_RD: begin
        cmd.op    = pli_pkg::OP_RD_CLAMP;
        state_nxt = S_CL_SET;
      end
      S_CL_SET: begin
        cmd.op    = pli_pkg::OP_CLAMP;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and divide step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* sv/pli_dp.sv */
// ----------------------------------------------------------------------------
// pli_dp
// Datapath: configuration registers, breakpoint and level memories, search
// registers, shared 32x16 multiplier, restoring divider and output register.
// ----------------------------------------------------------------------------
module pli_dp #(
  parameter int MAX_POINTS = 32,
  parameter int NUM_CURVES = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata,
  // request payload
  input  logic [1:0]          in_func,
  input  logic [5:0]          in_curve,
  input  logic [4:0]          in_point,
  input  logic [31:0]         in_position,
  input  logic signed [31:0]  in_level,
  // control
  input  pli_pkg::cmd_t       cmd,
  output pli_pkg::sts_t       sts,
  // result
  input  logic                out_ready,
  output logic                out_valid,
  output logic signed [31:0]  out_value,
  output logic [2:0]          out_status
);

  localparam int PW  = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int EW  = (NW > 6) ? NW : 6;
  localparam int LAW = $clog2(NUM_CURVES * MAX_POINTS);
  localparam int LVD = NUM_CURVES * MAX_POINTS;

  // Configuration registers
  logic [5:0]  piu_r;
  logic [15:0] tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r <= 6'd32;
      tol_r <= 16'd1;
    end else if (cfg_we) begin
      if (cfg_index == pli_pkg::CFG_POINTS) begin
        piu_r <= cfg_wdata[5:0];
      end else begin
        tol_r <= cfg_wdata;
      end
    end
  end

  // Points in use, clamped to the legal range
  logic [EW-1:0] piu_e;
  logic [NW-1:0] n_clip;
  assign piu_e  = EW'(piu_r);
  assign n_clip = (piu_e < EW'(2))          ? NW'(2) :
                  (piu_e > EW'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(piu_e);

  // Request and working registers
  logic [1:0]    func_r;
  logic [5:0]    curve_r;
  logic [4:0]    pt_r;
  logic [31:0]   pos_r;
  logic [31:0]   lvl_r;
  logic [NW-1:0] n_r;
  logic [NW-1:0] idx_r;
  logic [PW-1:0] seg_r;
  logic [31:0]   lo_r, prev_r;
  logic [31:0]   y1_r, mag_r, dx_r, wid_r;
  logic          neg_r;
  logic [63:0]   prod_r;
  logic [31:0]   rem_r, dq_r;
  logic [31:0]   res_value_r;
  logic [2:0]    res_status_r;
  logic [31:0]   bp_q_r, lv_q_r;

  logic [NW-1:0] nm1, idx_m2;
  assign nm1    = n_r - NW'(1);
  assign idx_m2 = idx_r - NW'(2);

  // Write range checks
  logic pt_ok, curve_ok;
  assign pt_ok    = 32'(pt_r) < MAX_POINTS;
  assign curve_ok = 32'(curve_r) < NUM_CURVES;

  // Breakpoint memory, single port, registered read
  logic [31:0]   bp_mem [MAX_POINTS];
  logic [PW-1:0] bp_addr;
  logic          bp_we;

  always_comb begin
    case (cmd.op)
      pli_pkg::OP_RD_HI: bp_addr = nm1[PW-1:0];
      pli_pkg::OP_CHECK,
      pli_pkg::OP_STEP:  bp_addr = idx_r[PW-1:0];
      pli_pkg::OP_WRITE: bp_addr = PW'(pt_r);
      default:           bp_addr = '0;
    endcase
  end

  assign bp_we = (cmd.op == pli_pkg::OP_WRITE) && (func_r == pli_pkg::FN_BP) && pt_ok;

  always_ff @(posedge clk) begin
    if (bp_we) begin
      bp_mem[bp_addr] <= pos_r;
    end
    bp_q_r <= bp_mem[bp_addr];
  end

  // Level memory, row per curve, single port, registered read
  logic [31:0]    lv_mem [LVD];
  logic [PW-1:0]  lv_pt;
  logic [LAW-1:0] lv_addr;
  logic           lv_we;

  always_comb begin
    case (cmd.op)
      pli_pkg::OP_RD_Y1:    lv_pt = seg_r;
      pli_pkg::OP_RD_Y2:    lv_pt = seg_r + PW'(1);
      pli_pkg::OP_RD_CLAMP: lv_pt = nm1[PW-1:0];
      default:              lv_pt = PW'(pt_r);
    endcase
  end

  assign lv_addr = LAW'(curve_r) * LAW'(MAX_POINTS) + LAW'(lv_pt);
  assign lv_we   = (cmd.op == pli_pkg::OP_WRITE) && (func_r == pli_pkg::FN_LV) &&
                   pt_ok && curve_ok;

  always_ff @(posedge clk) begin
    if (lv_we) begin
      lv_mem[lv_addr] <= lvl_r;
    end
    lv_q_r <= lv_mem[lv_addr];
  end

  // Bounds and search compares
  logic        below, above, in_tol, hit;
  logic [31:0] over;
  assign below  = pos_r <= lo_r;
  assign above  = pos_r >= bp_q_r;
  assign over   = pos_r - bp_q_r;
  assign in_tol = over <= {16'b0, tol_r};
  assign hit    = (prev_r <= pos_r) && (pos_r < bp_q_r);

  // Level difference magnitude and sign
  logic [32:0] diff, dabs;
  assign diff = {lv_q_r[31], lv_q_r} - {y1_r[31], y1_r};
  assign dabs = diff[32] ? (33'd0 - diff) : diff;

  // Shared 32x16 multiplier
  logic [15:0] mul_b;
  logic [47:0] pp;
  assign mul_b = (cmd.op == pli_pkg::OP_MUL_HI) ? dx_r[31:16] : dx_r[15:0];
  assign pp    = {16'b0, mag_r} * {32'b0, mul_b};

  // One restoring divide step
  logic [32:0] trial, tsub;
  logic        ge;
  assign trial = {rem_r, dq_r[31]};
  assign ge    = trial >= {1'b0, wid_r};
  assign tsub  = trial - {1'b0, wid_r};

  // Datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      pli_pkg::OP_LOAD: begin
        func_r  <= in_func;
        curve_r <= in_curve;
        pt_r    <= in_point;
        pos_r   <= in_position;
        lvl_r   <= in_level;
        n_r     <= n_clip;
        idx_r   <= NW'(1);
      end
      pli_pkg::OP_WRITE: begin
        res_value_r  <= '0;
        res_status_r <= pli_pkg::ST_WRITE;
      end
      pli_pkg::OP_SET: begin
        res_value_r  <= '0;
        res_status_r <= cmd.st;
      end
      pli_pkg::OP_WRAP: begin
        curve_r <= curve_r - 6'(NUM_CURVES);
      end
      pli_pkg::OP_RD_HI: begin
        lo_r <= bp_q_r;
      end
      pli_pkg::OP_CHECK: begin
        prev_r <= lo_r;
        idx_r  <= idx_r + NW'(1);
        if (below) begin
          res_value_r  <= '0;
          res_status_r <= pli_pkg::ST_BELOW;
        end else if (above && !in_tol) begin
          res_value_r  <= '0;
          res_status_r <= pli_pkg::ST_BEYOND;
        end
      end
      pli_pkg::OP_STEP: begin
        if (hit) begin
          seg_r <= idx_m2[PW-1:0];
          dx_r  <= pos_r - prev_r;
          wid_r <= bp_q_r - prev_r;
        end else begin
          prev_r <= bp_q_r;
          idx_r  <= idx_r + NW'(1);
          res_value_r  <= '0;
          res_status_r <= pli_pkg::ST_NOSEG;
        end
      end
      pli_pkg::OP_RD_Y2: begin
        y1_r <= lv_q_r;
      end
      pli_pkg::OP_PREP: begin
        neg_r <= diff[32];
        mag_r <= dabs[31:0];
      end
      pli_pkg::OP_MUL_LO: begin
        prod_r <= {16'b0, pp};
      end
      pli_pkg::OP_MUL_HI: begin
        prod_r <= prod_r + {pp, 16'b0};
      end
      pli_pkg::OP_DIV_INIT: begin
        rem_r <= prod_r[63:32];
        dq_r  <= prod_r[31:0];
      end
      pli_pkg::OP_DIV_STEP: begin
        rem_r <= ge ? tsub[31:0] : trial[31:0];
        dq_r  <= {dq_r[30:0], ge};
      end
      pli_pkg::OP_INTERP: begin
        res_value_r  <= neg_r ? (y1_r - dq_r) : (y1_r + dq_r);
        res_status_r <= pli_pkg::ST_INTERP;
      end
      pli_pkg::OP_CLAMP: begin
        res_value_r  <= lv_q_r;
        res_status_r <= pli_pkg::ST_CLAMP;
      end
      default: begin
      end
    endcase
  end

  // Output register
  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic [2:0]  out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  // Status back to the controller
  assign sts.func      = func_r;
  assign sts.curve_big = 32'(curve_r) >= NUM_CURVES;
  assign sts.below     = below;
  assign sts.beyond    = !below && above && !in_tol;
  assign sts.clamp     = !below && above && in_tol;
  assign sts.hit       = hit;
  assign sts.last      = idx_r == n_r;
  assign sts.out_free  = !out_valid_r || out_ready;

endmodule

/* sv/pli_checker.sv */
// ----------------------------------------------------------------------------
// pli_checker
// Port-level checks for the interpolator: result hold under backpressure,
// legal status codes, zero value for non-level results, busy after a request.
// ----------------------------------------------------------------------------
module pli_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_value,
  input logic [2:0]         out_status
);

  // Stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_status))
    else $error("result changed while stalled");

  // Only defined status codes leave the block
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= pli_pkg::ST_NOSEG)
    else $error("undefined status code");

  // Value is zero unless interpolated or clamped
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pli_pkg::ST_INTERP && out_status != pli_pkg::ST_CLAMP
    |-> out_value == 32'sd0)
    else $error("nonzero value with non-level status");

  // One request in flight: busy right after acceptance
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind piecewise_linear_interpolator_unit pli_checker u_pli_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_value  (out_value),
  .out_status (out_status)
);
